[hw/rtl/nwb_pkg.sv]
// nwb_pkg: shared constants, codes and types of the normalized window blur.
// No dependencies; compiled first.
`default_nettype none
package nwb_pkg;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_WINDOW = 5;
	localparam int HEIGHT_LIMIT   = 4096;
	localparam int CHANNELS       = 3;

	localparam int OP_W    = 2;
	localparam int WIDX_W  = 5;
	localparam int PIX_W   = 8;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 12;
	localparam int CFG_W   = 13;
	localparam int CFGI_W  = 2;

	// sized for a window of up to 9x9
	localparam int ACC_W   = 23;
	localparam int WSUM_W  = 15;
	localparam int QUO_W   = 8;

	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
	localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

	localparam logic [CFGI_W-1:0] REG_WIDTH    = 2'd0;
	localparam logic [CFGI_W-1:0] REG_HEIGHT   = 2'd1;
	localparam logic [CFGI_W-1:0] REG_WINDOW   = 2'd2;
	localparam logic [CFGI_W-1:0] REG_CHANNELS = 2'd3;

	typedef struct packed {
		logic              start;
		logic [ACC_W-1:0]  dividend;
		logic [WSUM_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;
endpackage
`default_nettype wire

[hw/rtl/nwb_stream_if.sv]
// nwb_stream_if: request and result channels (valid/ready plus payload).
// Depends on nwb_pkg for field widths.
`default_nettype none
interface nwb_in_if;
	logic                             valid;
	logic                             ready;
	logic [nwb_pkg::OP_W-1:0]         op;
	logic [nwb_pkg::WIDX_W-1:0]       weight_index;
	logic [nwb_pkg::PIX_W-1:0]        weight_value;
	logic [nwb_pkg::PIX_W-1:0]        red_in;
	logic [nwb_pkg::PIX_W-1:0]        green_in;
	logic [nwb_pkg::PIX_W-1:0]        blue_in;
	modport source (output valid, op, weight_index, weight_value, red_in, green_in, blue_in,
		input ready);
	modport sink (input valid, op, weight_index, weight_value, red_in, green_in, blue_in,
		output ready);
endinterface

interface nwb_out_if;
	logic                       valid;
	logic                       ready;
	logic [nwb_pkg::PIX_W-1:0]  red_out;
	logic [nwb_pkg::PIX_W-1:0]  green_out;
	logic [nwb_pkg::PIX_W-1:0]  blue_out;
	logic [nwb_pkg::COL_W-1:0]  column;
	logic [nwb_pkg::ROW_W-1:0]  row;
	logic                       frame_last;
	modport source (output valid, red_out, green_out, blue_out, column, row, frame_last,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, column, row, frame_last,
		output ready);
endinterface
`default_nettype wire

[hw/rtl/nwb_line_store.sv]
// nwb_line_store: pixel row buffer, one write and one registered read port.
// Depends on nwb_pkg.
`default_nettype none
module nwb_line_store #(
	parameter int MAX_WIDTH  = nwb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_WINDOW = nwb_pkg::DEF_MAX_WINDOW,
	localparam int DEPTH = MAX_WIDTH * MAX_WINDOW,
	localparam int AW    = $clog2(DEPTH),
	localparam int DW    = nwb_pkg::CHANNELS * nwb_pkg::PIX_W
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/nwb_divider.sv]
// nwb_divider: restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on nwb_pkg (div_req_t, div_rsp_t).
`default_nettype none
module nwb_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire nwb_pkg::div_req_t req,
	output nwb_pkg::div_rsp_t      rsp
);
	localparam int AW = nwb_pkg::ACC_W;
	localparam int QW = nwb_pkg::QUO_W;

	logic              busy_q;
	logic              done_q;
	logic [2:0]        cnt_q;
	logic [AW-1:0]     rem_q;
	logic [AW-1:0]     den_q;
	logic [QW-1:0]     quo_q;
	logic              fits;

	assign fits = rem_q >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 3'(QW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 3'd1;
			if (cnt_q == 3'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			den_q <= AW'(req.divisor) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - den_q;
			end
			quo_q <= {quo_q[QW-2:0], fits};
			den_q <= den_q >> 1;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

[hw/rtl/normalized_window_blur.sv]
// normalized_window_blur: streaming normalized 2-D window blur, a MAC per channel, one shared divider.
// Weight load and no-op: taken in idle. Pixel or drain with an output ready: accept and check,
// then (2*half+1)^2 taps (one line store read each), a flush, 3 divisions and an emit
// that waits while the previous result is held. No output ready: accept and check only.
// Not ready while an item is at work. Reset: registers 64, 64, 5, 3; weights zero;
// positions zero; line store not cleared.
`default_nettype none
module normalized_window_blur #(
	parameter int MAX_WIDTH  = nwb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_WINDOW = nwb_pkg::DEF_MAX_WINDOW
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [nwb_pkg::CFGI_W-1:0]   cfg_index,
	input  wire logic [nwb_pkg::CFG_W-1:0]    cfg_data,
	nwb_in_if.sink                            upstream,
	nwb_out_if.source                         downstream
);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int WW    = XW + 1;
	localparam int CXW   = XW + 2;
	localparam int YW    = nwb_pkg::ROW_W;
	localparam int HW    = YW + 1;
	localparam int CYW   = YW + 2;
	localparam int SLOTS = MAX_WINDOW * MAX_WINDOW;
	localparam int KIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KW    = $clog2(SLOTS + MAX_WINDOW + 1);
	localparam int SW    = $clog2((MAX_WINDOW > 1) ? MAX_WINDOW : 2);
	localparam int ZW    = $clog2(MAX_WINDOW + 1) + 1;
	localparam int HALF_CAP = (MAX_WINDOW - 1) / 2;
	localparam int AW    = $clog2(MAX_WIDTH * MAX_WINDOW);
	localparam int PW    = nwb_pkg::PIX_W;
	localparam int DW    = nwb_pkg::CHANNELS * PW;
	localparam int ACW   = nwb_pkg::ACC_W;
	localparam int WSW   = nwb_pkg::WSUM_W;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CHECK  = 7'b0000010,
		ST_TAP    = 7'b0000100,
		ST_FLUSH  = 7'b0001000,
		ST_DSTART = 7'b0010000,
		ST_DWAIT  = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [10:0] image_width_q;
	logic [12:0] image_height_q;
	logic [2:0]  window_size_q;
	logic [1:0]  channel_count_q;

	logic [PW-1:0] weights_q [SLOTS];

	logic [XW-1:0] in_x_q, out_x_q;
	logic [YW-1:0] in_y_q, out_y_q;
	logic [SW-1:0] in_slot_q, out_slot_q;
	logic          ahead_q;

	logic [ZW-1:0]        i_q, j_q;
	logic [KW-1:0]        k_row_q;
	logic signed [CXW-1:0] cx_q;
	logic signed [CYW-1:0] cy_q;
	logic [SW-1:0]        tslot_q, slot0_q;

	logic          tap_ok_s1;
	logic [PW-1:0] wt_s1;
	logic [ACW-1:0] acc_q [nwb_pkg::CHANNELS];
	logic [WSW-1:0] wsum_q;
	logic [1:0]     ch_q;
	logic [PW-1:0]  quo_q [nwb_pkg::CHANNELS];

	logic          out_valid_q;
	logic [PW-1:0] red_q, green_q, blue_q;
	logic [nwb_pkg::COL_W-1:0] col_q;
	logic [YW-1:0] row_q;
	logic          last_q;

	// effective configuration
	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic [ZW-1:0] eff_size, half_raw, half, last_idx;
	logic [1:0]    chans;

	always_comb begin
		if (image_width_q == '0) eff_w = WW'(1);
		else if (32'(image_width_q) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
		else eff_w = WW'(image_width_q);
		if (image_height_q == '0) eff_h = HW'(1);
		else if (32'(image_height_q) > nwb_pkg::HEIGHT_LIMIT) eff_h = HW'(nwb_pkg::HEIGHT_LIMIT);
		else eff_h = HW'(image_height_q);
		if (32'(window_size_q) > MAX_WINDOW) eff_size = ZW'(MAX_WINDOW);
		else eff_size = ZW'(window_size_q);
		half_raw = eff_size >> 1;
		half     = (32'(half_raw) > HALF_CAP) ? ZW'(HALF_CAP) : half_raw;
		last_idx = half << 1;
		chans    = (channel_count_q == 2'd0) ? 2'd1 : channel_count_q;
	end

	// readiness of the next output
	logic [WW-1:0] cx_lim_raw, cx_lim;
	logic [HW-1:0] cy_lim_raw, cy_lim;
	logic          out_ready;

	always_comb begin
		cx_lim_raw = WW'(out_x_q) + WW'(half);
		cy_lim_raw = HW'(out_y_q) + HW'(half);
		cx_lim = (cx_lim_raw > eff_w - WW'(1)) ? eff_w - WW'(1) : cx_lim_raw;
		cy_lim = (cy_lim_raw > eff_h - HW'(1)) ? eff_h - HW'(1) : cy_lim_raw;
		out_ready = ahead_q || (cy_lim < HW'(in_y_q))
			|| ((cy_lim == HW'(in_y_q)) && (cx_lim < WW'(in_x_q)));
	end

	// first tap row slot
	logic [SW:0] slot0_sum, slot0;
	always_comb begin
		slot0_sum = (SW+1)'(out_slot_q) + (SW+1)'(MAX_WINDOW) - (SW+1)'(half);
		slot0 = (32'(slot0_sum) >= MAX_WINDOW) ? slot0_sum - (SW+1)'(MAX_WINDOW) : slot0_sum;
	end

	// tap address and validity
	logic [KW-1:0] k;
	logic          tap_ok;
	logic [AW-1:0] raddr;
	logic [PW-1:0] wt_rd;
	always_comb begin
		k = k_row_q + KW'(j_q);
		tap_ok = !cx_q[CXW-1] && (CXW'($unsigned(cx_q)) < CXW'(eff_w))
			&& !cy_q[CYW-1] && (CYW'($unsigned(cy_q)) < CYW'(eff_h))
			&& (32'(k) < SLOTS);
		raddr = AW'(tslot_q) * AW'(MAX_WIDTH) + AW'(cx_q[XW-1:0]);
		wt_rd = (32'(k) < SLOTS) ? weights_q[k[KIW-1:0]] : '0;
	end

	// request accept and line store write
	logic in_acc, pix_we, out_free, geo_wr;
	logic [AW-1:0] waddr;
	logic [DW-1:0] rdata;
	assign upstream.ready = (state_q == ST_IDLE);
	assign in_acc   = upstream.valid && upstream.ready;
	assign pix_we   = in_acc && (upstream.op == nwb_pkg::OP_PIXEL);
	assign waddr    = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_x_q);
	assign out_free = !out_valid_q || downstream.ready;
	// geometry writes restart the frame
	assign geo_wr   = cfg_we && (cfg_index != nwb_pkg::REG_CHANNELS);

	nwb_line_store #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_store (
		.clk   (clk),
		.we    (pix_we),
		.waddr (waddr),
		.wdata ({upstream.blue_in, upstream.green_in, upstream.red_in}),
		.raddr (raddr),
		.rdata (rdata)
	);

	nwb_pkg::div_req_t div_req;
	nwb_pkg::div_rsp_t div_rsp;
	assign div_req.start    = (state_q == ST_DSTART);
	assign div_req.dividend = acc_q[ch_q];
	assign div_req.divisor  = wsum_q;

	nwb_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer, positions and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			image_width_q   <= 11'd64;
			image_height_q  <= 13'd64;
			window_size_q   <= 3'd5;
			channel_count_q <= 2'd3;
			in_x_q     <= '0;
			in_y_q     <= '0;
			in_slot_q  <= '0;
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_slot_q <= '0;
			ahead_q    <= 1'b0;
			ch_q       <= '0;
			tap_ok_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < SLOTS; s++) weights_q[s] <= '0;
		end else begin
			tap_ok_s1 <= (state_q == ST_TAP) && tap_ok;
			if ((state_q == ST_EMIT) && out_free) out_valid_q <= 1'b1;
			else if (downstream.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (upstream.op)
							nwb_pkg::OP_LOAD: begin
								if (32'(upstream.weight_index) < SLOTS)
									weights_q[KIW'(upstream.weight_index)] <= upstream.weight_value;
							end
							nwb_pkg::OP_PIXEL: begin
								state_q <= ST_CHECK;
								if (!geo_wr) begin
									if (WW'(in_x_q) == eff_w - WW'(1)) begin
										in_x_q <= '0;
										if (HW'(in_y_q) == eff_h - HW'(1)) begin
											in_y_q    <= '0;
											in_slot_q <= '0;
											ahead_q   <= 1'b1;
										end else begin
											in_y_q    <= in_y_q + YW'(1);
											in_slot_q <= (32'(in_slot_q) == MAX_WINDOW - 1)
												? '0 : in_slot_q + SW'(1);
										end
									end else begin
										in_x_q <= in_x_q + XW'(1);
									end
								end
							end
							nwb_pkg::OP_DRAIN: state_q <= ST_CHECK;
							default: ;
						endcase
					end
				end
				ST_CHECK: begin
					state_q <= out_ready ? ST_TAP : ST_IDLE;
					ch_q    <= '0;
				end
				ST_TAP: begin
					if (j_q == last_idx) begin
						if (i_q == last_idx) state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_rsp.done) begin
						if (ch_q == 2'(nwb_pkg::CHANNELS - 1)) begin
							state_q <= ST_EMIT;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= ST_DSTART;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (!geo_wr) begin
							if (WW'(out_x_q) == eff_w - WW'(1)) begin
								out_x_q <= '0;
								if (HW'(out_y_q) == eff_h - HW'(1)) begin
									out_y_q    <= '0;
									out_slot_q <= '0;
									ahead_q    <= 1'b0;
								end else begin
									out_y_q    <= out_y_q + YW'(1);
									out_slot_q <= (32'(out_slot_q) == MAX_WINDOW - 1)
										? '0 : out_slot_q + SW'(1);
								end
							end else begin
								out_x_q <= out_x_q + XW'(1);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					nwb_pkg::REG_WIDTH:    image_width_q   <= cfg_data[10:0];
					nwb_pkg::REG_HEIGHT:   image_height_q  <= cfg_data[12:0];
					nwb_pkg::REG_WINDOW:   window_size_q   <= cfg_data[2:0];
					nwb_pkg::REG_CHANNELS: channel_count_q <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (geo_wr) begin
				in_x_q     <= '0;
				in_y_q     <= '0;
				in_slot_q  <= '0;
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_slot_q <= '0;
				ahead_q    <= 1'b0;
			end
		end
	end

	// tap walk and MAC datapath
	always_ff @(posedge clk) begin
		wt_s1 <= wt_rd;
		if (state_q == ST_CHECK) begin
			i_q     <= '0;
			j_q     <= '0;
			k_row_q <= '0;
			cx_q    <= $signed(CXW'(out_x_q)) - $signed(CXW'(half));
			cy_q    <= $signed(CYW'(out_y_q)) - $signed(CYW'(half));
			slot0_q <= SW'(slot0);
			tslot_q <= SW'(slot0);
			wsum_q  <= '0;
			for (int c = 0; c < nwb_pkg::CHANNELS; c++) acc_q[c] <= '0;
		end else begin
			if (state_q == ST_TAP) begin
				if (j_q == last_idx) begin
					j_q     <= '0;
					i_q     <= i_q + ZW'(1);
					k_row_q <= k_row_q + KW'(eff_size);
					cx_q    <= cx_q + CXW'(1);
					cy_q    <= $signed(CYW'(out_y_q)) - $signed(CYW'(half));
					tslot_q <= slot0_q;
				end else begin
					j_q     <= j_q + ZW'(1);
					cy_q    <= cy_q + CYW'(1);
					tslot_q <= (32'(tslot_q) == MAX_WINDOW - 1) ? '0 : tslot_q + SW'(1);
				end
			end
			if (tap_ok_s1) begin
				wsum_q <= wsum_q + WSW'(wt_s1);
				for (int c = 0; c < nwb_pkg::CHANNELS; c++)
					acc_q[c] <= acc_q[c] + ACW'(wt_s1) * ACW'(rdata[PW*c +: PW]);
			end
		end
		if ((state_q == ST_DWAIT) && div_rsp.done) quo_q[ch_q] <= div_rsp.quotient;
	end

	// result register
	logic nz;
	assign nz = (wsum_q != '0);
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			red_q   <= nz ? quo_q[0] : '0;
			green_q <= (nz && chans >= 2'd2) ? quo_q[1] : '0;
			blue_q  <= (nz && chans == 2'd3) ? quo_q[2] : '0;
			col_q   <= nwb_pkg::COL_W'(out_x_q);
			row_q   <= out_y_q;
			last_q  <= (WW'(out_x_q) == eff_w - WW'(1)) && (HW'(out_y_q) == eff_h - HW'(1));
		end
	end

	assign downstream.valid      = out_valid_q;
	assign downstream.red_out    = red_q;
	assign downstream.green_out  = green_q;
	assign downstream.blue_out   = blue_q;
	assign downstream.column     = col_q;
	assign downstream.row        = row_q;
	assign downstream.frame_last = last_q;

	a_mac_after_tap: assert property (@(posedge clk) disable iff (!arst_n)
		tap_ok_s1 |-> $past(state_q == ST_TAP))
		else $error("MAC fired outside the tap walk");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("emission did not load the result register");

	a_pixel_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (upstream.op == nwb_pkg::OP_PIXEL || upstream.op == nwb_pkg::OP_DRAIN)
			&& !cfg_we) |=> (state_q == ST_CHECK))
		else $error("pixel or drain request did not reach the readiness check");
endmodule
`default_nettype wire
